// File: rtl/ptree_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptree_pkg: shared constants and types of the palindromic tree block
// Sizes of the text, node and child stores, the node record and the states.
// ----------------------------------------------------------------------------
package ptree_pkg;

   localparam int MaxLen     = 1024;
   localparam int Alphabet   = 26;
   localparam int NodeCap    = MaxLen + 2;
   localparam int ChildDepth = NodeCap * Alphabet;

   localparam int TextAw  = $clog2(MaxLen);
   localparam int NodeW   = $clog2(NodeCap);
   localparam int ChildAw = $clog2(ChildDepth);
   localparam int SymW    = 5;

   // one node of the tree as stored in the node memory
   typedef struct packed {
      logic [11:0]      len;
      logic [NodeW-1:0] link;
      logic [10:0]      depth;
      logic [9:0]       start;
   } node_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_W_ADDR,
      ST_W_TEXT,
      ST_W_CMP,
      ST_W_DONE,
      ST_C_DATA,
      ST_L_DATA,
      ST_H_DATA,
      ST_D_DATA,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/palindromic_tree_append_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_append_top: online palindromic tree, one symbol per word
// Appends each symbol to the text, walks suffix links through the node memory
// and creates nodes, reporting the longest palindromic suffix and counts.
// ----------------------------------------------------------------------------
//  channel   ports                      direction
//  req       req_valid/ready, symbol    in: one symbol a word
//  rsp       rsp_valid/ready, 8 fields  out: one result word per symbol
//
//  A symbol walks suffix links: each node is tested against the text, a node
//  reaching back past the text start is skipped, the imaginary root matches.
//  A new node longer than one adds a second walk for its suffix link. A symbol
//  dropped on a full string skips the walk.
//  After reset the child table is cleared, one entry a cycle, all 26676
//  entries; no word is taken meanwhile.
//  A result waits in the output register; the next word is taken once it has
//  been moved there.
// ----------------------------------------------------------------------------
module palindromic_tree_append_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_pal_id,
   output logic [10:0] rsp_pal_length,
   output logic [9:0]  rsp_pal_start,
   output logic [10:0] rsp_suffix_pal_count,
   output logic        rsp_is_new,
   output logic [10:0] rsp_distinct_count,
   output logic [19:0] rsp_total_count,
   output logic        rsp_overflow
);

   localparam int NW = ptree_pkg::NodeW;
   localparam int CW = ptree_pkg::ChildAw;
   localparam int TW = ptree_pkg::TextAw;

   // memories
   logic [ptree_pkg::SymW-1:0] text_mem  [ptree_pkg::MaxLen];
   ptree_pkg::node_type        node_mem  [ptree_pkg::NodeCap];
   logic [NW-1:0]              child_mem [ptree_pkg::ChildDepth];

   logic                       text_we;
   logic [TW-1:0]              text_waddr, text_raddr;
   logic [ptree_pkg::SymW-1:0] text_rdata_ff;
   logic                       node_we;
   logic [NW-1:0]              node_waddr, node_raddr;
   ptree_pkg::node_type        node_wdata, node_rdata_ff;
   logic                       child_we;
   logic [CW-1:0]              child_waddr, child_raddr;
   logic [NW-1:0]              child_wdata, child_rdata_ff;

   // control and data registers
   ptree_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]              clr_ff, clr_in;
   logic [ptree_pkg::SymW-1:0] sym_ff, sym_in;
   logic [NW-1:0]              v_ff, v_in;
   logic [11:0]                vlen_ff, vlen_in;
   logic [NW-1:0]              vlink_ff, vlink_in;
   logic                       phase_ff, phase_in;
   logic [NW-1:0]              now_ff, now_in;
   logic [11:0]                nowlen_ff, nowlen_in;
   logic [NW-1:0]              nowlink_ff, nowlink_in;
   logic [11:0]                newlen_ff, newlen_in;
   logic [NW-1:0]              newlink_ff, newlink_in;
   logic [10:0]                tl_ff, tl_in;
   logic [NW-1:0]              ntot_ff, ntot_in;
   logic [19:0]                occ_ff, occ_in;
   logic [NW-1:0]              last_ff, last_in;
   logic [11:0]                lastlen_ff, lastlen_in;
   logic [9:0]                 laststart_ff, laststart_in;
   logic [10:0]                lastdepth_ff, lastdepth_in;
   logic                       isnew_ff, isnew_in;
   logic                       ovf_ff, ovf_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       load_out;

   logic [ptree_pkg::SymW-1:0] sym_sat;
   logic [12:0]                pos;
   logic [11:0]                len_new;
   logic [10:0]                depth_new;
   logic [9:0]                 start_new;

   assign sym_sat = (req_symbol >= ptree_pkg::SymW'(ptree_pkg::Alphabet))
                    ? ptree_pkg::SymW'(ptree_pkg::Alphabet - 1) : req_symbol;
   assign pos = {2'b00, tl_ff} - {node_rdata_ff.len[11], node_rdata_ff.len} - 13'd1;
   assign len_new   = nowlen_ff + 12'd2;
   assign depth_new = node_rdata_ff.depth + 11'd1;
   assign start_new = tl_ff[9:0] + 10'd1 - newlen_ff[9:0];

   assign child_raddr = CW'(v_ff * ptree_pkg::Alphabet) + CW'(sym_ff);
   assign req_ready   = (state_ff == ptree_pkg::ST_IDLE);
   assign load_out    = (state_ff == ptree_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // memory ports
   always_ff @(posedge clock) begin
      if (text_we) text_mem[text_waddr] <= sym_in;
      text_rdata_ff <= text_mem[text_raddr];
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rdata_ff <= node_mem[node_raddr];
      if (child_we) child_mem[child_waddr] <= child_wdata;
      child_rdata_ff <= child_mem[child_raddr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptree_pkg::ST_CLEAR:
            if (clr_ff == CW'(ptree_pkg::ChildDepth - 1)) state_in = ptree_pkg::ST_IDLE;
         ptree_pkg::ST_IDLE:
            if (req_valid) begin
               state_in = (tl_ff == 11'(ptree_pkg::MaxLen)) ? ptree_pkg::ST_EMIT
                                                            : ptree_pkg::ST_W_ADDR;
            end
         ptree_pkg::ST_W_ADDR:
            state_in = (v_ff == '0) ? ptree_pkg::ST_W_DONE : ptree_pkg::ST_W_TEXT;
         ptree_pkg::ST_W_TEXT:
            state_in = pos[12] ? ptree_pkg::ST_W_ADDR : ptree_pkg::ST_W_CMP;
         ptree_pkg::ST_W_CMP:
            state_in = (text_rdata_ff == sym_ff) ? ptree_pkg::ST_W_DONE
                                                 : ptree_pkg::ST_W_ADDR;
         ptree_pkg::ST_W_DONE:
            state_in = phase_ff ? ptree_pkg::ST_L_DATA : ptree_pkg::ST_C_DATA;
         ptree_pkg::ST_C_DATA:
            if (child_rdata_ff != '0)  state_in = ptree_pkg::ST_H_DATA;
            else if (len_new == 12'd1) state_in = ptree_pkg::ST_D_DATA;
            else                       state_in = ptree_pkg::ST_W_ADDR;
         ptree_pkg::ST_L_DATA: state_in = ptree_pkg::ST_D_DATA;
         ptree_pkg::ST_H_DATA: state_in = ptree_pkg::ST_EMIT;
         ptree_pkg::ST_D_DATA: state_in = ptree_pkg::ST_EMIT;
         ptree_pkg::ST_EMIT:
            if (load_out) state_in = ptree_pkg::ST_IDLE;
         default: state_in = ptree_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in       = clr_ff;
      sym_in       = sym_ff;
      v_in         = v_ff;
      vlen_in      = vlen_ff;
      vlink_in     = vlink_ff;
      phase_in     = phase_ff;
      now_in       = now_ff;
      nowlen_in    = nowlen_ff;
      nowlink_in   = nowlink_ff;
      newlen_in    = newlen_ff;
      newlink_in   = newlink_ff;
      tl_in        = tl_ff;
      ntot_in      = ntot_ff;
      occ_in       = occ_ff;
      last_in      = last_ff;
      lastlen_in   = lastlen_ff;
      laststart_in = laststart_ff;
      lastdepth_in = lastdepth_ff;
      isnew_in     = isnew_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      text_we      = 1'b0;
      text_waddr   = tl_ff[TW-1:0];
      text_raddr   = pos[TW-1:0];
      node_we      = 1'b0;
      node_waddr   = ntot_ff;
      node_raddr   = v_ff;
      node_wdata   = '{len: newlen_ff, link: newlink_ff, depth: depth_new,
                       start: start_new};
      child_we     = 1'b0;
      child_waddr  = CW'(now_ff * ptree_pkg::Alphabet) + CW'(sym_ff);
      child_wdata  = ntot_ff;
      case (state_ff)
         // sweep the child table, seeding both roots on the way
         ptree_pkg::ST_CLEAR: begin
            clr_in      = clr_ff + CW'(1);
            child_we    = 1'b1;
            child_waddr = clr_ff;
            child_wdata = '0;
            node_we     = (clr_ff < CW'(2));
            node_waddr  = clr_ff[NW-1:0];
            node_wdata  = '{len: (clr_ff == '0) ? 12'hFFF : 12'h000,
                            link: '0, depth: '0, start: '0};
         end
         ptree_pkg::ST_IDLE:
            if (req_valid) begin
               sym_in   = sym_sat;
               v_in     = last_ff;
               phase_in = 1'b0;
               isnew_in = 1'b0;
               ovf_in   = (tl_ff == 11'(ptree_pkg::MaxLen));
               text_we  = (tl_ff != 11'(ptree_pkg::MaxLen));
            end
         // root of imaginary length always matches
         ptree_pkg::ST_W_ADDR:
            if (v_ff == '0) begin
               vlen_in  = 12'hFFF;
               vlink_in = '0;
            end
         ptree_pkg::ST_W_TEXT: begin
            vlen_in  = node_rdata_ff.len;
            vlink_in = node_rdata_ff.link;
            if (pos[12]) v_in = node_rdata_ff.link;
         end
         ptree_pkg::ST_W_CMP:
            if (text_rdata_ff != sym_ff) v_in = vlink_ff;
         ptree_pkg::ST_W_DONE:
            if (!phase_ff) begin
               now_in     = v_ff;
               nowlen_in  = vlen_ff;
               nowlink_in = vlink_ff;
            end
         // existing child or start of a new node
         ptree_pkg::ST_C_DATA: begin
            node_raddr = child_rdata_ff;
            newlen_in  = len_new;
            newlink_in = NW'(1);
            if (child_rdata_ff != '0) begin
               last_in = child_rdata_ff;
            end else if (len_new == 12'd1) begin
               node_raddr = NW'(1);
            end else begin
               v_in     = nowlink_ff;
               phase_in = 1'b1;
            end
         end
         ptree_pkg::ST_L_DATA: begin
            newlink_in = child_rdata_ff;
            node_raddr = child_rdata_ff;
         end
         ptree_pkg::ST_H_DATA: begin
            lastlen_in   = node_rdata_ff.len;
            laststart_in = node_rdata_ff.start;
            lastdepth_in = node_rdata_ff.depth;
            occ_in       = occ_ff + 20'(node_rdata_ff.depth);
            tl_in        = tl_ff + 11'd1;
         end
         // commit the new node
         ptree_pkg::ST_D_DATA: begin
            node_we      = 1'b1;
            child_we     = 1'b1;
            last_in      = ntot_ff;
            lastlen_in   = newlen_ff;
            laststart_in = start_new;
            lastdepth_in = depth_new;
            occ_in       = occ_ff + 20'(depth_new);
            tl_in        = tl_ff + 11'd1;
            ntot_in      = ntot_ff + NW'(1);
            isnew_in     = 1'b1;
         end
         ptree_pkg::ST_EMIT:
            if (load_out) rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptree_pkg::ST_CLEAR;
         clr_ff       <= '0;
         tl_ff        <= '0;
         ntot_ff      <= NW'(2);
         occ_ff       <= '0;
         last_ff      <= NW'(1);
         lastlen_ff   <= '0;
         laststart_ff <= '0;
         lastdepth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         tl_ff        <= tl_in;
         ntot_ff      <= ntot_in;
         occ_ff       <= occ_in;
         last_ff      <= last_in;
         lastlen_ff   <= lastlen_in;
         laststart_ff <= laststart_in;
         lastdepth_ff <= lastdepth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff     <= sym_in;
      v_ff       <= v_in;
      vlen_ff    <= vlen_in;
      vlink_ff   <= vlink_in;
      phase_ff   <= phase_in;
      now_ff     <= now_in;
      nowlen_ff  <= nowlen_in;
      nowlink_ff <= nowlink_in;
      newlen_ff  <= newlen_in;
      newlink_ff <= newlink_in;
      isnew_ff   <= isnew_in;
      ovf_ff     <= ovf_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_pal_id           <= 10'(last_ff - NW'(2));
         rsp_pal_length       <= lastlen_ff[10:0];
         rsp_pal_start        <= laststart_ff;
         rsp_suffix_pal_count <= lastdepth_ff;
         rsp_is_new           <= isnew_ff;
         rsp_distinct_count   <= 11'(ntot_ff - NW'(2));
         rsp_total_count      <= occ_ff;
         rsp_overflow         <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
